/* rtl/core/gl_pkg.sv */
`default_nettype none

package gl_pkg;

  localparam int unsigned COORD_W   = 20;
  localparam int unsigned DIG_W     = 5;
  localparam int unsigned PAIRS     = 5;
  localparam int unsigned LEVELS    = 4;
  localparam int unsigned MAX_RADIX = 24;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned NPAIRS_W  = 3;
  localparam int unsigned IN_W      = 48;
  localparam int unsigned OUT_W     = 80;

  localparam logic [COORD_W+1:0] HALF_SPAN = 22'd518400;
  localparam logic [COORD_W+1:0] FULL_SPAN = 22'd1036800;
  localparam logic [COORD_W-1:0] LAST_CELL = 20'd1036799;

  // grid step in finest units and radix for the four split levels
  localparam logic [COORD_W:0] STEP [LEVELS] = '{21'd57600, 21'd5760, 21'd240, 21'd24};
  localparam logic [DIG_W-1:0] RADIX [LEVELS] = '{5'd18, 5'd10, 5'd24, 5'd10};

  localparam logic [CHAR_W-1:0] LETTER_BASE = 7'd65;
  localparam logic [CHAR_W-1:0] NUMBER_BASE = 7'd48;

  localparam logic [NPAIRS_W-1:0] MIN_PAIRS = 3'd2;
  localparam logic [NPAIRS_W-1:0] MAX_PAIRS = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0]             lat;
    logic [COORD_W-1:0]             lon;
    logic [LEVELS-1:0][DIG_W-1:0]   lat_dig;
    logic [LEVELS-1:0][DIG_W-1:0]   lon_dig;
    logic [NPAIRS_W-1:0]            npairs;
  } gl_item_t;

  typedef struct packed {
    logic [DIG_W-1:0]   dig;
    logic [COORD_W-1:0] rem;
  } gl_split_t;

  // quotient and remainder by the level's step, x known below radix*step;
  // parallel threshold compares, the highest passing one wins
  function automatic gl_split_t split_digit(input logic [COORD_W-1:0] x,
                                            input int unsigned lvl);
    gl_split_t       res;
    logic [COORD_W:0] thr;
    res.dig = '0;
    res.rem = x;
    for (int k = 1; k < MAX_RADIX; k++) begin
      thr = (COORD_W+1)'(k * STEP[lvl]);
      if (DIG_W'(k) < RADIX[lvl] && {1'b0, x} >= thr) begin
        res.dig = DIG_W'(k);
        res.rem = COORD_W'({1'b0, x} - thr);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gl_front.sv */
`default_nettype none

module gl_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [gl_pkg::IN_W-1:0]  in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output gl_pkg::gl_item_t              out_item_o
);

  logic             valid_q;
  gl_pkg::gl_item_t item_q, item_d;

  function automatic logic [gl_pkg::COORD_W-1:0] shift_clamp(
      input logic [gl_pkg::COORD_W-1:0] raw);
    logic [gl_pkg::COORD_W+1:0] sum;
    sum = {{2{raw[gl_pkg::COORD_W-1]}}, raw} + gl_pkg::HALF_SPAN;
    if (sum[gl_pkg::COORD_W+1]) begin
      return '0;
    end else if (sum >= gl_pkg::FULL_SPAN) begin
      return gl_pkg::LAST_CELL;
    end else begin
      return sum[gl_pkg::COORD_W-1:0];
    end
  endfunction

  logic [gl_pkg::NPAIRS_W-1:0] pairs;

  always_comb begin
    pairs          = in_data_i[2*gl_pkg::COORD_W +: gl_pkg::NPAIRS_W];
    item_d         = '0;
    item_d.lat     = shift_clamp(in_data_i[0 +: gl_pkg::COORD_W]);
    item_d.lon     = shift_clamp(in_data_i[gl_pkg::COORD_W +: gl_pkg::COORD_W]);
    if (pairs <= gl_pkg::MIN_PAIRS) begin
      item_d.npairs = gl_pkg::MIN_PAIRS;
    end else if (pairs >= gl_pkg::MAX_PAIRS) begin
      item_d.npairs = gl_pkg::MAX_PAIRS;
    end else begin
      item_d.npairs = pairs;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gl_digits.sv */
`default_nettype none

module gl_digits (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  gl_pkg::gl_item_t  in_item_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output gl_pkg::gl_item_t  out_item_o
);

  // one register stage per split level
  gl_pkg::gl_item_t               item_q [gl_pkg::LEVELS];
  gl_pkg::gl_item_t               item_d [gl_pkg::LEVELS];
  logic [gl_pkg::LEVELS-1:0]      valid_q;
  logic [gl_pkg::LEVELS:0]        rdy;
  logic [gl_pkg::LEVELS-1:0]      vin;
  gl_pkg::gl_item_t               src [gl_pkg::LEVELS];

  assign rdy[gl_pkg::LEVELS] = out_ready_i;

  for (genvar g = 0; g < gl_pkg::LEVELS; g++) begin : g_lvl
    gl_pkg::gl_split_t lat_s, lon_s;

    if (g == 0) begin : g_first
      assign src[g] = in_item_i;
      assign vin[g] = in_valid_i;
    end else begin : g_next
      assign src[g] = item_q[g-1];
      assign vin[g] = valid_q[g-1];
    end

    assign rdy[g] = !valid_q[g] || rdy[g+1];

    always_comb begin
      lat_s             = gl_pkg::split_digit(src[g].lat, g);
      lon_s             = gl_pkg::split_digit(src[g].lon, g);
      item_d[g]         = src[g];
      item_d[g].lat     = lat_s.rem;
      item_d[g].lon     = lon_s.rem;
      item_d[g].lat_dig[g] = lat_s.dig;
      item_d[g].lon_dig[g] = lon_s.dig;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        valid_q[g] <= vin[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && vin[g]) begin
        item_q[g] <= item_d[g];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[gl_pkg::LEVELS-1];
  assign out_item_o  = item_q[gl_pkg::LEVELS-1];

endmodule

`default_nettype wire

/* rtl/core/gl_format.sv */
`default_nettype none

module gl_format (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  gl_pkg::gl_item_t              in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [gl_pkg::OUT_W-1:0]      out_data_o
);

  logic                        valid_q;
  logic [gl_pkg::OUT_W-1:0]    data_q, data_d;

  always_comb begin
    logic [gl_pkg::DIG_W-1:0]  lon_d, lat_d;
    logic [gl_pkg::CHAR_W-1:0] base;
    data_d = '0;
    for (int p = 0; p < gl_pkg::PAIRS; p++) begin
      // last level digit is whatever is left over
      if (p < gl_pkg::LEVELS) begin
        lon_d = in_item_i.lon_dig[p];
        lat_d = in_item_i.lat_dig[p];
      end else begin
        lon_d = in_item_i.lon[gl_pkg::DIG_W-1:0];
        lat_d = in_item_i.lat[gl_pkg::DIG_W-1:0];
      end
      base = (p % 2 == 1) ? gl_pkg::NUMBER_BASE : gl_pkg::LETTER_BASE;
      if (gl_pkg::NPAIRS_W'(p) < in_item_i.npairs) begin
        data_d[2*p*gl_pkg::CHAR_W +: gl_pkg::CHAR_W]     = base + {2'b00, lon_d};
        data_d[(2*p+1)*gl_pkg::CHAR_W +: gl_pkg::CHAR_W] = base + {2'b00, lat_d};
      end
    end
    data_d[2*gl_pkg::PAIRS*gl_pkg::CHAR_W +: gl_pkg::LEN_W] = {in_item_i.npairs, 1'b0};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/latlon_to_grid_locator_core.sv */
// Pipeline: clamp register, four digit-split stages, character format register.
// Throughput: one beat per cycle while the output is not stalled; each stage holds
// one item and its valid bit, and a stall only backs up stages that are full.
// Reset: rst_ni clears all stage valid bits; data registers are not reset.
`default_nettype none

module latlon_to_grid_locator_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [19:0] latitude, [39:20] longitude, [42:40] pairs_wanted, [47:43] zero
  input  wire logic [gl_pkg::IN_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [6:0] char_0 ... [69:63] char_9, [73:70] locator_length, [79:74] zero
  output logic [gl_pkg::OUT_W-1:0]     m_axis_tdata
);

  logic             fr_valid, fr_ready, dg_valid, dg_ready;
  gl_pkg::gl_item_t fr_item, dg_item;

  gl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  gl_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (dg_valid),
    .out_ready_i (dg_ready),
    .out_item_o  (dg_item)
  );

  gl_format u_format (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dg_valid),
    .in_ready_o  (dg_ready),
    .in_item_i   (dg_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // input backs up only when the whole pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[73:70] == 4'd4 || m_axis_tdata[73:70] == 4'd6 ||
                       m_axis_tdata[73:70] == 4'd8 || m_axis_tdata[73:70] == 4'd10))
    else $error("bad locator length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[73:70] == 4'd4) |-> (m_axis_tdata[69:28] == '0))
    else $error("unused characters not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] >= 7'd65 && m_axis_tdata[6:0] <= 7'd82 &&
                       m_axis_tdata[20:14] >= 7'd48 && m_axis_tdata[20:14] <= 7'd57))
    else $error("field or square character out of range");
`endif

endmodule

`default_nettype wire

/* tb/latlon_to_grid_locator_core_tb.sv */
`default_nettype none

module latlon_to_grid_locator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM   = 1425;
  localparam int DRAIN_AT     = 700;   // random item that waits for an empty pipe
  localparam int HOLD_AFTER   = 200;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 150;
  localparam int CALM_LO      = 900;
  localparam int CALM_HI      = 1150;
  localparam int TAIL_CYCLES  = 20;
  localparam int HALF_RANGE   = 518400;
  localparam int FULL_RANGE   = 1036800;
  localparam int unsigned CELL_STEP [5] = '{57600, 5760, 240, 24, 1};
  localparam logic [6:0] LETTER_A = 7'd65;
  localparam logic [6:0] DIGIT_0  = 7'd48;

  typedef struct {
    logic signed [19:0] lat;
    logic signed [19:0] lon;
    logic [2:0]         pairs;
    bit                 drain_first;
  } position_t;

  typedef struct packed {
    logic [5:0]       pad;
    logic [3:0]       len;
    logic [9:0][6:0]  ch;
  } locator_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [gl_pkg::IN_W-1:0] s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [gl_pkg::OUT_W-1:0] m_axis_tdata;

  position_t pending_positions [$];
  locator_t  expected_locators [$];
  position_t offered;
  int        positions_sent = 0;
  int        locators_seen  = 0;
  int        error_count    = 0;

  latlon_to_grid_locator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // shift to non-negative and saturate into [0, FULL_RANGE-1]
  function automatic int unsigned grid_offset(logic signed [19:0] coord);
    int v;
    v = int'(coord) + HALF_RANGE;
    if (v < 0) v = 0;
    if (v >= FULL_RANGE) v = FULL_RANGE - 1;
    return int'(v);
  endfunction

  function automatic locator_t encode_locator(position_t p);
    locator_t    loc;
    int unsigned lat_u;
    int unsigned lon_u;
    int unsigned npairs;
    logic [6:0]  base;
    lat_u = grid_offset(p.lat);
    lon_u = grid_offset(p.lon);
    if (p.pairs <= 3'd2) npairs = 2;
    else if (p.pairs >= 3'd5) npairs = 5;
    else npairs = 32'(p.pairs);
    loc = '0;
    for (int i = 0; i < 5; i++) begin
      base = (i % 2 == 1) ? DIGIT_0 : LETTER_A;
      if (i < npairs) begin
        loc.ch[2*i]   = base + 7'(lon_u / CELL_STEP[i]);
        loc.ch[2*i+1] = base + 7'(lat_u / CELL_STEP[i]);
      end
      lon_u = lon_u % CELL_STEP[i];
      lat_u = lat_u % CELL_STEP[i];
    end
    loc.len = 4'(npairs * 2);
    return loc;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t result %0d: %s got %0d want %0d",
             $realtime, locators_seen, what, got, want);
    error_count++;
  endtask

  task automatic check_locator(logic [gl_pkg::OUT_W-1:0] beat);
    locator_t got;
    locator_t want;
    got = beat;
    if (expected_locators.size() == 0) begin
      report_mismatch("unexpected beat, tdata low word", int'(beat[31:0]), 0);
    end else begin
      want = expected_locators.pop_front();
      for (int i = 0; i < 10; i++)
        if (got.ch[i] !== want.ch[i])
          report_mismatch($sformatf("char_%0d", i), int'(got.ch[i]), int'(want.ch[i]));
      if (got.len !== want.len)
        report_mismatch("locator_length", int'(got.len), int'(want.len));
      if (got.pad !== want.pad)
        report_mismatch("pad bits", int'(got.pad), 0);
    end
  endtask

  task automatic add_position(int lat, int lon, int pairs, bit drain_first);
    position_t p;
    p.lat = 20'(lat);
    p.lon = 20'(lon);
    p.pairs = 3'(pairs);
    p.drain_first = drain_first;
    pending_positions.push_back(p);
  endtask

  // sender
  always @(posedge clk_i) begin : drive
    bit        give;
    bit        quiet;
    position_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_locators.push_back(encode_locator(offered));
        positions_sent++;
      end
      // a beat on offer and not taken stays put
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        give  = 1'b0;
        quiet = (positions_sent >= CALM_LO && positions_sent < CALM_HI);
        if (pending_positions.size() > 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
          if (!(pending_positions[0].drain_first && expected_locators.size() > 0))
            give = 1'b1;
        end
        if (give) begin
          nxt = pending_positions.pop_front();
          offered       <= nxt;
          s_axis_tdata  <= {5'b0, nxt.pairs, nxt.lon, nxt.lat};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int  hold_left = 0;
  bit  held_once = 1'b0;

  always @(posedge clk_i) begin : watch
    bit ready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_locator(m_axis_tdata);
        locators_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (!held_once && locators_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        ready = 1'b0;
      end else if (locators_seen >= CALM_LO && locators_seen < CALM_HI) begin
        ready = 1'b1;
      end else begin
        ready = ($urandom_range(0, 99) >= 9);
      end
      m_axis_tready <= ready;
    end
  end

  initial begin : stimulus
    int lat;
    int lon;
    int sel;

    // every length selection at the grid center
    for (int k = 0; k < 8; k++) add_position(0, 0, k, 1'b0);
    add_position(-HALF_RANGE, -HALF_RANGE, 5, 1'b0);
    // exactly at the upper bound: saturates into the last cell
    add_position(HALF_RANGE, HALF_RANGE, 5, 1'b0);
    add_position(HALF_RANGE - 1, HALF_RANGE - 1, 5, 1'b0);
    // beyond range on both sides
    add_position(-524288, -524288, 7, 1'b0);
    add_position(524287, 524287, 6, 1'b0);
    add_position(-HALF_RANGE - 1, HALF_RANGE + 1, 5, 1'b0);
    add_position(-1, -1, 5, 1'b0);
    // digit boundaries at each level
    add_position(-HALF_RANGE + 57599, -HALF_RANGE + 57600, 5, 1'b0);
    add_position(-HALF_RANGE + 5759, -HALF_RANGE + 5760, 5, 1'b0);
    add_position(-HALF_RANGE + 239, -HALF_RANGE + 240, 4, 1'b0);
    add_position(-HALF_RANGE + 23, -HALF_RANGE + 24, 3, 1'b0);
    add_position(HALF_RANGE, -HALF_RANGE, 1, 1'b0);
    add_position(-HALF_RANGE, HALF_RANGE, 2, 1'b0);
    add_position(12345, -98765, 5, 1'b0);
    add_position(349525, -349526, 5, 1'b0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        lat = $urandom_range(0, FULL_RANGE) - HALF_RANGE;
        lon = $urandom_range(0, FULL_RANGE) - HALF_RANGE;
      end else if (sel < 90) begin
        // any 20-bit pattern, out of range included
        lat = int'($signed(20'($urandom)));
        lon = int'($signed(20'($urandom)));
      end else begin
        lat = ($urandom_range(0, 1) ? HALF_RANGE : -HALF_RANGE) + $urandom_range(0, 4) - 2;
        lon = ($urandom_range(0, 1) ? HALF_RANGE : -HALF_RANGE) + $urandom_range(0, 4) - 2;
      end
      add_position(lat, lon, $urandom_range(0, 7), n == DRAIN_AT);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_positions.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_locators.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_locators.size() != 0)
      report_mismatch("results left over", expected_locators.size(), 0);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #500us;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/gl_pkg.sv
rtl/core/gl_front.sv
rtl/core/gl_digits.sv
rtl/core/gl_format.sv
rtl/core/latlon_to_grid_locator_core.sv
tb/latlon_to_grid_locator_core_tb.sv
